[rtl/mss_pkg.sv]
// shared types and constants for the multiplexed seven-segment driver
package mss_pkg;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_TEXT     = 3'd1,
    OP_NUMBER   = 3'd2,
    OP_TIME     = 3'd3,
    OP_BRIGHTER = 3'd4,
    OP_DIMMER   = 3'd5
  } op_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ON_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_MAX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_STEP  = 3'd5;

  localparam logic [CFG_W-1:0] ON_MIN_RESET  = 16'd50;
  localparam logic [CFG_W-1:0] ON_MAX_RESET  = 16'd2000;
  localparam logic [CFG_W-1:0] ON_STEP_RESET = 16'd50;
  localparam logic [CFG_W-1:0] IV_MIN_RESET  = 16'd0;
  localparam logic [CFG_W-1:0] IV_MAX_RESET  = 16'd20000;
  localparam logic [CFG_W-1:0] IV_STEP_RESET = 16'd1000;

  typedef struct packed {
    logic busy;
    logic acc;
    logic lit;
  } scan_info_t;

endpackage

[rtl/mss_scan_ctrl.sv]
// scan timing, request admission, brightness and configuration registers
module mss_scan_ctrl import mss_pkg::*; #(
  parameter int DIGITS     = 4,
  parameter int TICK_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  op_t                    op,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  output scan_info_t             info,
  output logic [$clog2(DIGITS+1)-1:0] idx
);

  localparam int NSLOTS = DIGITS + 1;
  localparam int SLW    = $clog2(NSLOTS);
  localparam int CNTW   = $clog2(NSLOTS + 1);
  localparam int CW     = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;

  logic [CFG_W-1:0] on_min, on_max, on_step, iv_min, iv_max, iv_step;

  logic [CFG_W-1:0]      lit_time, lit_time_next;
  logic [CFG_W-1:0]      redraw_pause, redraw_pause_next;
  logic [TICK_WIDTH-1:0] since_frame, since_frame_next;
  logic [SLW-1:0]        slot_index, slot_index_next;
  logic [CNTW-1:0]       slot_count, slot_count_next;
  logic [CFG_W-1:0]      dwell_count, dwell_count_next;
  logic                  scanning, scanning_next;

  logic            show_ok;
  logic [CFG_W:0]  dwell_sum;
  logic [CNTW-1:0] idx_inc;
  logic [CFG_W:0]  lit_sum, pause_sum;
  logic [CFG_W-1:0] lit_sub, pause_sub;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_min  <= ON_MIN_RESET;
      on_max  <= ON_MAX_RESET;
      on_step <= ON_STEP_RESET;
      iv_min  <= IV_MIN_RESET;
      iv_max  <= IV_MAX_RESET;
      iv_step <= IV_STEP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ON_MIN:  on_min  <= cfg_data;
        CFG_ON_MAX:  on_max  <= cfg_data;
        CFG_ON_STEP: on_step <= cfg_data;
        CFG_IV_MIN:  iv_min  <= cfg_data;
        CFG_IV_MAX:  iv_max  <= cfg_data;
        CFG_IV_STEP: iv_step <= cfg_data;
        default: ;
      endcase
    end
  end

  assign show_ok   = !scanning && (CW'(since_frame) >= CW'(redraw_pause));
  assign dwell_sum = {1'b0, dwell_count} + 1'b1;
  assign idx_inc   = CNTW'(slot_index) + 1'b1;
  assign lit_sum   = {1'b0, lit_time} + {1'b0, on_step};
  assign pause_sum = {1'b0, redraw_pause} + {1'b0, iv_step};
  assign lit_sub   = (lit_time > on_step) ? lit_time - on_step : '0;
  assign pause_sub = (redraw_pause > iv_step) ? redraw_pause - iv_step : '0;

  always_comb begin
    lit_time_next     = lit_time;
    redraw_pause_next = redraw_pause;
    since_frame_next  = since_frame;
    slot_index_next   = slot_index;
    slot_count_next   = slot_count;
    dwell_count_next  = dwell_count;
    scanning_next     = scanning;
    case (op)
      OP_TICK: begin
        if (scanning) begin
          if (dwell_sum >= {1'b0, lit_time}) begin
            dwell_count_next = '0;
            if (idx_inc >= slot_count) begin
              scanning_next    = 1'b0;
              slot_index_next  = '0;
              since_frame_next = '0;
            end else begin
              slot_index_next = idx_inc[SLW-1:0];
            end
          end else begin
            dwell_count_next = dwell_sum[CFG_W-1:0];
          end
        end else if (since_frame != '1) begin
          since_frame_next = since_frame + 1'b1;
        end
      end
      OP_TEXT, OP_NUMBER, OP_TIME: begin
        if (show_ok) begin
          slot_count_next  = (op == OP_TIME) ? CNTW'(NSLOTS) : CNTW'(DIGITS);
          slot_index_next  = '0;
          dwell_count_next = '0;
          scanning_next    = 1'b1;
        end
      end
      OP_BRIGHTER: begin
        if (redraw_pause > iv_min) begin
          redraw_pause_next = (pause_sub > iv_min) ? pause_sub : iv_min;
        end else begin
          lit_time_next = (lit_sum < {1'b0, on_max}) ? lit_sum[CFG_W-1:0] : on_max;
        end
      end
      OP_DIMMER: begin
        if (lit_time > on_min) begin
          lit_time_next = (lit_sub > on_min) ? lit_sub : on_min;
        end else begin
          redraw_pause_next = (pause_sum < {1'b0, iv_max}) ? pause_sum[CFG_W-1:0] : iv_max;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lit_time     <= ON_MAX_RESET;
      redraw_pause <= IV_MIN_RESET;
      since_frame  <= '1;
      slot_index   <= '0;
      slot_count   <= '0;
      dwell_count  <= '0;
      scanning     <= 1'b0;
    end else if (accept) begin
      lit_time     <= lit_time_next;
      redraw_pause <= redraw_pause_next;
      since_frame  <= since_frame_next;
      slot_index   <= slot_index_next;
      slot_count   <= slot_count_next;
      dwell_count  <= dwell_count_next;
      scanning     <= scanning_next;
    end
  end

  assign info.busy = scanning;
  assign info.acc  = show_ok && (op == OP_TEXT || op == OP_NUMBER || op == OP_TIME);
  assign info.lit  = scanning && (CNTW'(slot_index) < slot_count);
  assign idx       = slot_index;

endmodule

[rtl/mux_seven_segment_driver.sv]
// multiplexed seven-segment display driver, top level
// one transaction per cycle unless held; a result is valid once its input
// transaction has passed the input register, two digit conversion stages and
// result register; the whole pipeline holds while a result waits on out_ready
// rst is synchronous: all valids clear, timing state and registers return to
// their reset values; slot patterns are not cleared and are written before use
module mux_seven_segment_driver import mss_pkg::*; #(
  parameter int DIGITS     = 4,
  parameter int TICK_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           operation,
  input  logic [7:0]           char_digit1,
  input  logic [7:0]           char_digit2,
  input  logic [7:0]           char_digit3,
  input  logic [7:0]           char_digit4,
  input  logic [15:0]          show_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           segments,
  output logic [3:0]           digit_enable,
  output logic                 busy_res,
  output logic                 accepted,
  output logic                 unknown_char,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int NSLOTS = DIGITS + 1;
  localparam int SLW    = $clog2(NSLOTS);
  localparam int PW     = 8 + DIGITS;
  localparam logic [16:0] MINS_RECIP = 17'd69906;
  localparam logic [7:0]  SEG_COLON  = 8'h80;

  function automatic logic [8:0] glyph(input logic [7:0] ch);
    logic [8:0] r;
    r = 9'h000;
    case (ch)
      8'h20, 8'h00: r = 9'h000;
      8'h30, 8'h4F: r = 9'h03F;
      8'h31:        r = 9'h006;
      8'h32:        r = 9'h05B;
      8'h33:        r = 9'h04F;
      8'h34:        r = 9'h066;
      8'h35:        r = 9'h06D;
      8'h36:        r = 9'h07D;
      8'h37:        r = 9'h007;
      8'h38:        r = 9'h07F;
      8'h39, 8'h67: r = 9'h06F;
      8'h42, 8'h62: r = 9'h07C;
      8'h69:        r = 9'h010;
      8'h44, 8'h64: r = 9'h05E;
      8'h45, 8'h65: r = 9'h079;
      8'h46:        r = 9'h071;
      8'h6C:        r = 9'h030;
      8'h6F:        r = 9'h05C;
      8'h52, 8'h72: r = 9'h050;
      8'h59:        r = 9'h06E;
      8'h56, 8'h55: r = 9'h022;
      8'h75, 8'h76: r = 9'h01C;
      8'h3A:        r = 9'h080;
      default:      r = 9'h100;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    logic [7:0] r;
    r = 8'h00;
    case (d)
      4'd0: r = 8'h3F;
      4'd1: r = 8'h06;
      4'd2: r = 8'h5B;
      4'd3: r = 8'h4F;
      4'd4: r = 8'h66;
      4'd5: r = 8'h6D;
      4'd6: r = 8'h7D;
      4'd7: r = 8'h07;
      4'd8: r = 8'h7F;
      4'd9: r = 8'h6F;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // shift-add-3 over eight input bits
  function automatic logic [19:0] dabble(input logic [19:0] b_in, input logic [7:0] bits);
    logic [19:0] b;
    b = b_in;
    for (int s = 7; s >= 0; s--) begin
      for (int n = 0; n < 5; n++) begin
        if (b[4*n +: 4] >= 4'd5) b[4*n +: 4] = b[4*n +: 4] + 4'd3;
      end
      b = {b[18:0], bits[s]};
    end
    return b;
  endfunction

  function automatic logic [3:0] bcd_digit(input logic [19:0] b, input int k);
    logic [3:0] r;
    r = 4'd0;
    if (k >= 0 && k < 5) r = b[4*k +: 4];
    return r;
  endfunction

  logic       advance, accept;
  scan_info_t ctrl_info;
  logic [SLW-1:0] ctrl_idx;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && advance;

  mss_scan_ctrl #(
    .DIGITS     (DIGITS),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (op_t'(operation)),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .info      (ctrl_info),
    .idx       (ctrl_idx)
  );

  // input register
  logic           s1_vld;
  op_t            s1_op;
  logic [7:0]     s1_chars [4];
  logic [15:0]    s1_val;
  scan_info_t     s1_info;
  logic [SLW-1:0] s1_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (advance) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op       <= op_t'(operation);
      s1_chars[0] <= char_digit1;
      s1_chars[1] <= char_digit2;
      s1_chars[2] <= char_digit3;
      s1_chars[3] <= char_digit4;
      s1_val      <= show_value;
      s1_info     <= ctrl_info;
      s1_idx      <= ctrl_idx;
    end
  end

  // minutes and seconds split, text glyphs
  logic [32:0] a_prod;
  logic [10:0] a_mins;
  logic [16:0] a_m60;
  logic [15:0] a_secs_w;
  logic [7:0]  a_glyph [DIGITS];
  logic        a_bad;
  logic [8:0]  a_g;

  assign a_prod   = 33'(s1_val) * 33'(MINS_RECIP);
  assign a_mins   = a_prod[32:22];
  assign a_m60    = {a_mins, 6'b0} - 17'({a_mins, 2'b0});
  assign a_secs_w = s1_val - a_m60[15:0];

  always_comb begin
    a_bad = 1'b0;
    a_g   = '0;
    for (int i = 0; i < DIGITS; i++) begin
      a_glyph[i] = 8'h00;
      if (i < 4) begin
        a_g        = glyph(s1_chars[2'(i)]);
        a_glyph[i] = a_g[7:0];
        a_bad      = a_bad | a_g[8];
      end
    end
  end

  logic           s2_vld;
  op_t            s2_op;
  logic [15:0]    s2_bin;
  logic [5:0]     s2_secs;
  logic [7:0]     s2_glyph [DIGITS];
  logic           s2_unk;
  scan_info_t     s2_info;
  logic [SLW-1:0] s2_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (advance) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_op    <= s1_op;
      s2_bin   <= (s1_op == OP_TIME) ? 16'(a_mins) : s1_val;
      s2_secs  <= a_secs_w[5:0];
      s2_glyph <= a_glyph;
      s2_unk   <= s1_info.acc && (s1_op == OP_TEXT) && a_bad;
      s2_info  <= s1_info;
      s2_idx   <= s1_idx;
    end
  end

  // upper byte of the binary-to-decimal conversion, seconds digits
  logic [19:0] b_bcd;
  logic [2:0]  b_tens;
  logic [6:0]  b_tens10;
  logic [5:0]  b_units_w;

  assign b_bcd = dabble(20'd0, s2_bin[15:8]);

  always_comb begin
    if      (s2_secs >= 6'd50) b_tens = 3'd5;
    else if (s2_secs >= 6'd40) b_tens = 3'd4;
    else if (s2_secs >= 6'd30) b_tens = 3'd3;
    else if (s2_secs >= 6'd20) b_tens = 3'd2;
    else if (s2_secs >= 6'd10) b_tens = 3'd1;
    else                       b_tens = 3'd0;
  end

  assign b_tens10  = {1'b0, b_tens, 3'b0} + {3'b0, b_tens, 1'b0};
  assign b_units_w = s2_secs - b_tens10[5:0];

  logic           s3_vld;
  op_t            s3_op;
  logic [11:0]    s3_bcd_hi;
  logic [7:0]     s3_bin_lo;
  logic [3:0]     s3_tens, s3_units;
  logic [7:0]     s3_glyph [DIGITS];
  logic           s3_unk;
  scan_info_t     s3_info;
  logic [SLW-1:0] s3_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (advance) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_op     <= s2_op;
      s3_bcd_hi <= b_bcd[11:0];
      s3_bin_lo <= s2_bin[7:0];
      s3_tens   <= 4'(b_tens);
      s3_units  <= b_units_w[3:0];
      s3_glyph  <= s2_glyph;
      s3_unk    <= s2_unk;
      s3_info   <= s2_info;
      s3_idx    <= s2_idx;
    end
  end

  // finish conversion, build slot patterns
  logic [19:0]       c_bcd;
  logic [PW-1:0]     c_pat [NSLOTS];
  logic [NSLOTS-1:0] c_wr;
  logic [7:0]        c_seg;
  logic [DIGITS-1:0] c_oh;
  int                c_fromr;

  assign c_bcd = dabble({8'd0, s3_bcd_hi}, s3_bin_lo);

  always_comb begin
    c_seg   = '0;
    c_oh    = '0;
    c_fromr = 0;
    for (int s = 0; s < NSLOTS; s++) begin
      c_pat[s] = '0;
      c_wr[s]  = 1'b0;
    end
    if (s3_op == OP_TIME) begin
      c_oh     = '0;
      c_oh[0]  = 1'b1;
      c_pat[0] = {c_oh, SEG_COLON};
      c_wr[0]  = 1'b1;
    end
    for (int i = 0; i < DIGITS; i++) begin
      c_fromr = DIGITS - 1 - i;
      c_oh    = '0;
      c_oh[i] = 1'b1;
      case (s3_op)
        OP_TEXT:   c_seg = s3_glyph[i];
        OP_NUMBER: c_seg = digit_seg(bcd_digit(c_bcd, c_fromr));
        default: begin
          if (c_fromr == 0)      c_seg = digit_seg(s3_units);
          else if (c_fromr == 1) c_seg = digit_seg(s3_tens);
          else                   c_seg = digit_seg(bcd_digit(c_bcd, c_fromr - 2));
        end
      endcase
      if (s3_op == OP_TIME) begin
        c_pat[i+1] = {c_oh, c_seg};
        c_wr[i+1]  = 1'b1;
      end else begin
        c_pat[i] = {c_oh, c_seg};
        c_wr[i]  = 1'b1;
      end
    end
  end

  logic [PW-1:0] slot_patterns [NSLOTS];

  always_ff @(posedge clk) begin
    if (advance && s3_vld && s3_info.acc) begin
      for (int s = 0; s < NSLOTS; s++) begin
        if (c_wr[s]) slot_patterns[s] <= c_pat[s];
      end
    end
  end

  logic [PW-1:0] rd_pat;
  logic [7:0]    rd_oh;

  assign rd_pat = slot_patterns[s3_idx];
  assign rd_oh  = 8'(rd_pat[PW-1:8]);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      segments     <= s3_info.lit ? rd_pat[7:0] : 8'h00;
      digit_enable <= s3_info.lit ? rd_oh[3:0] : 4'h0;
      busy_res     <= s3_info.busy;
      accepted     <= s3_info.acc;
      unknown_char <= s3_unk;
    end
  end

endmodule
